// ===== rtl/core/psu_pkg.sv =====
package psu_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] ROW_BYTES_RST    = 16'd4;
  localparam logic [3:0]  BYTES_PER_PX_RST = 4'd4;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd1;

  // output queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // one item on its way from the sequencer to the reconstruction stage
  typedef struct packed {
    logic       err;
    filt_t      filt;
    logic       has_above;
    logic       row_last;
    logic       img_last;
    logic [7:0] data;
  } s1_item_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       image_end;
    logic       status;
  } pix_t;

  // paeth predictor: pick the neighbor closest to left + above - upper_left
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    logic [7:0] pick;
    pa = $signed({3'b000, b}) - $signed({3'b000, c});
    pb = $signed({3'b000, a}) - $signed({3'b000, c});
    pc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) pick = a;
    else if (pb <= pc) pick = b;
    else pick = c;
    return pick;
  endfunction

endpackage

// ===== rtl/core/psu_ifs.sv =====
// inflated stream byte channel
interface psu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

// reconstructed pixel byte channel
interface psu_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_end;
  logic       image_end;
  logic       status;

  modport source (output valid, output pixel_byte, output row_end, output image_end,
                  output status, input ready);
  modport sink   (input valid, input pixel_byte, input row_end, input image_end,
                  input status, output ready);
endinterface

// ===== rtl/core/png_scanline_unfilter_unit.sv =====
// PNG scanline unfilter: takes the inflated image stream one byte per transaction and
// rebuilds the filtered rows (none, sub, up, average, Paeth) against a row store that
// holds the previous reconstructed row. Each row starts with a filter byte that gives no
// result; every data byte gives one result marked with row_end and image_end. An unknown
// filter byte gives a single result with status 1, after which bytes are dropped until
// the image of the configured height completes. The input takes one byte per clock while
// the output queue has room; each byte is registered into the stage register as the row
// store is read, then rebuilt and written to the output queue, whose four entries let
// the input keep flowing while results wait. The user must write configuration only
// while no transaction is in flight; the block itself does not enforce this.
module png_scanline_unfilter_unit #(
  parameter int MAX_ROW_BYTES = 32768,
  parameter int MAX_ROWS      = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [psu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data,
  psu_byte_if.sink                         stream_in,
  psu_pix_if.source                        pixel_out
);
  import psu_pkg::*;

  localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int RCW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [16:0] RB_MAX = 17'(MAX_ROW_BYTES);
  localparam logic [16:0] H_MAX  = 17'(MAX_ROWS);

  logic [15:0] row_bytes;
  logic [3:0]  bytes_per_pixel;
  logic [12:0] image_height;

  logic [16:0] rb_lim;
  logic [16:0] h_lim;
  logic [3:0]  bpp;

  logic         in_fire;
  logic         rd_en;
  logic [AW-1:0] rd_addr;
  logic         s1_valid;
  s1_item_t     s1_item;
  logic [AW-1:0] s1_col;
  logic         res_valid;
  pix_t         res;
  pix_t         dout;
  logic         not_empty;
  logic [OUTQ_CW-1:0] count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= ROW_BYTES_RST;
      bytes_per_pixel <= BYTES_PER_PX_RST;
      image_height    <= IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW_BYTES:    row_bytes       <= cfg_data;
        CFG_BYTES_PER_PX: bytes_per_pixel <= cfg_data[3:0];
        CFG_IMAGE_HEIGHT: image_height    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // clamp registers into their legal ranges
  always_comb begin
    if (row_bytes == 16'd0) rb_lim = 17'd1;
    else if (17'(row_bytes) > RB_MAX) rb_lim = RB_MAX;
    else rb_lim = 17'(row_bytes);

    if (image_height == 13'd0) h_lim = 17'd1;
    else if (17'(image_height) > H_MAX) h_lim = H_MAX;
    else h_lim = 17'(image_height);

    if (bytes_per_pixel == 4'd0) bpp = 4'd1;
    else if (bytes_per_pixel > 4'd8) bpp = 4'd8;
    else bpp = bytes_per_pixel;
  end

  // accept while the queue has room for everything in flight
  assign stream_in.ready = (4'(count) + 4'(s1_valid)) < 4'(OUTQ_DEPTH);
  assign in_fire         = stream_in.valid && stream_in.ready;

  psu_seq #(
    .AW  (AW),
    .RCW (RCW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_byte  (stream_in.stream_byte),
    .rb_lim   (rb_lim),
    .h_lim    (h_lim),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_col   (s1_col)
  );

  psu_recon #(
    .AW    (AW),
    .DEPTH (MAX_ROW_BYTES)
  ) u_recon (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_col    (s1_col),
    .bpp       (bpp),
    .res_valid (res_valid),
    .res       (res)
  );

  psu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .pop       (pixel_out.valid && pixel_out.ready),
    .dout      (dout),
    .not_empty (not_empty),
    .count     (count)
  );

  // result channel
  assign pixel_out.valid      = not_empty;
  assign pixel_out.pixel_byte = dout.pixel_byte;
  assign pixel_out.row_end    = dout.row_end;
  assign pixel_out.image_end  = dout.image_end;
  assign pixel_out.status     = dout.status;

endmodule

// ===== rtl/core/psu_seq.sv =====
module psu_seq #(
  parameter int AW  = 15,
  parameter int RCW = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [7:0]         in_byte,
  input  logic [16:0]        rb_lim,
  input  logic [16:0]        h_lim,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  output logic               s1_valid,
  output psu_pkg::s1_item_t  s1_item,
  output logic [AW-1:0]      s1_col
);
  import psu_pkg::*;

  logic           expect_filter;
  logic [AW-1:0]  col;
  logic [RCW-1:0] row_count;
  logic           failed;
  filt_t          cur_filt;

  logic row_last;
  logic img_last;
  logic bad_filter;

  // end of row and end of image for the byte at the input
  assign row_last   = (17'(col) + 17'd1) >= rb_lim;
  assign img_last   = row_last && ((17'(row_count) + 17'd1) >= h_lim);
  assign bad_filter = in_byte > 8'(FILT_PAETH);

  // row store read is issued with the data byte
  assign rd_en   = in_fire && !expect_filter && !failed;
  assign rd_addr = col;

  // position counters and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_filter <= 1'b1;
      col           <= '0;
      row_count     <= '0;
      failed        <= 1'b0;
      cur_filt      <= FILT_NONE;
    end else if (in_fire) begin
      if (expect_filter) begin
        expect_filter <= 1'b0;
        col           <= '0;
        if (!failed) begin
          if (bad_filter) failed <= 1'b1;
          else cur_filt <= filt_t'(in_byte[2:0]);
        end
      end else if (row_last) begin
        expect_filter <= 1'b1;
        if (img_last) begin
          row_count <= '0;
          failed    <= 1'b0;
        end else begin
          row_count <= row_count + RCW'(1);
        end
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // stage register toward reconstruction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire && !failed && (!expect_filter || bad_filter);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.err       <= expect_filter;
      s1_item.filt      <= cur_filt;
      s1_item.has_above <= row_count != '0;
      s1_item.row_last  <= row_last;
      s1_item.img_last  <= img_last;
      s1_item.data      <= in_byte;
      s1_col            <= col;
    end
  end

endmodule

// ===== rtl/core/psu_recon.sv =====
module psu_recon #(
  parameter int AW    = 15,
  parameter int DEPTH = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  input  logic               s1_valid,
  input  psu_pkg::s1_item_t  s1_item,
  input  logic [AW-1:0]      s1_col,
  input  logic [3:0]         bpp,
  output logic               res_valid,
  output psu_pkg::pix_t      res
);
  import psu_pkg::*;

  logic [7:0] row_mem [DEPTH];
  logic [7:0] rdata;
  logic [7:0] left_hist [8];
  logic [7:0] ul_hist [8];

  logic       has_left;
  logic [2:0] hidx;
  logic [2:0] widx;
  logic [7:0] left;
  logic [7:0] up;
  logic [7:0] ul;
  logic [8:0] avg_sum;
  logic [7:0] pred;
  logic [7:0] v;
  logic       wr_en;

  // neighbors of the byte in this stage
  assign has_left = 17'(s1_col) >= 17'(bpp);
  assign hidx     = 3'(s1_col) - bpp[2:0];
  assign widx     = 3'(s1_col);
  assign left     = has_left ? left_hist[hidx] : 8'd0;
  assign up       = s1_item.has_above ? rdata : 8'd0;
  assign ul       = (s1_item.has_above && has_left) ? ul_hist[hidx] : 8'd0;
  assign avg_sum  = {1'b0, left} + {1'b0, up};

  // predictor selected by the row filter
  always_comb begin
    unique case (s1_item.filt)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth_pick(left, up, ul);
      default:    pred = 8'd0;
    endcase
  end

  assign v     = s1_item.data + pred;
  assign wr_en = s1_valid && !s1_item.err;

  // row store: read with the byte at the input, written back from this stage
  always_ff @(posedge clk) begin
    if (rd_en) rdata <= row_mem[rd_addr];
    if (wr_en) row_mem[s1_col] <= v;
  end

  // left and upper-left history of the last eight columns
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        left_hist[i] <= 8'd0;
        ul_hist[i]   <= 8'd0;
      end
    end else if (wr_en) begin
      left_hist[widx] <= v;
      ul_hist[widx]   <= up;
    end
  end

  // result transaction
  assign res_valid = s1_valid;

  always_comb begin
    if (s1_item.err) begin
      res.pixel_byte = 8'd0;
      res.row_end    = 1'b0;
      res.image_end  = 1'b0;
      res.status     = 1'b1;
    end else begin
      res.pixel_byte = v;
      res.row_end    = s1_item.row_last;
      res.image_end  = s1_item.img_last;
      res.status     = 1'b0;
    end
  end

endmodule

// ===== rtl/core/psu_fifo.sv =====
module psu_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  psu_pkg::pix_t                 din,
  input  logic                          pop,
  output psu_pkg::pix_t                 dout,
  output logic                          not_empty,
  output logic [psu_pkg::OUTQ_CW-1:0]   count
);
  import psu_pkg::*;

  pix_t               entries [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr;
  logic [OUTQ_AW-1:0] rd_ptr;

  assign not_empty = count != '0;
  assign dout      = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + OUTQ_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + OUTQ_AW'(1);
      count <= count + OUTQ_CW'(push) - OUTQ_CW'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= din;
  end

endmodule

// ===== sim/tb_png_scanline_unfilter_unit.sv =====
module tb_png_scanline_unfilter_unit;
  import psu_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int ROW_STORE      = 32768;
  localparam int ROW_LIMIT      = 32768;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int RANDOM_ITEMS   = 800;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 2000000;

  // index with no register behind it, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_mode_t;
  typedef enum int {IMG_CLEAN, IMG_BROKEN, IMG_NOISE} img_flavor_t;

  // shadow of the unfilter state, predicts the pixel transactions in order
  class unfilter_board;
    logic [15:0] row_bytes_reg;
    logic [3:0]  bpp_reg;
    logic [12:0] height_reg;
    logic [7:0]  above_row [ROW_STORE];
    logic [7:0]  left_hist [8];
    logic [7:0]  ul_hist [8];
    int unsigned col_pos;
    int unsigned row_pos;
    filt_t       filter;
    bit          failed;
    pix_t        pixels_due [$];
    int          mismatches;

    function new();
      row_bytes_reg = ROW_BYTES_RST;
      bpp_reg       = BYTES_PER_PX_RST;
      height_reg    = IMAGE_HEIGHT_RST;
      foreach (left_hist[i]) begin
        left_hist[i] = 8'h00;
        ul_hist[i]   = 8'h00;
      end
      col_pos    = 0;
      row_pos    = 0;
      filter     = FILT_NONE;
      failed     = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_to(int unsigned x, int unsigned lo, int unsigned hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function int unsigned eff_row_bytes();
      return clamp_to(row_bytes_reg, 1, ROW_LIMIT);
    endfunction

    function int unsigned eff_height();
      return clamp_to(height_reg, 1, HEIGHT_LIMIT);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ROW_BYTES:    row_bytes_reg = data[15:0];
        CFG_BYTES_PER_PX: bpp_reg = data[3:0];
        CFG_IMAGE_HEIGHT: height_reg = data[12:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    // one accepted stream byte, queue the pixel it produces if any
    function void take_byte(logic [7:0] b);
      int unsigned rb, bpp, h, col;
      int          a, u, c, p, da, du, dc;
      logic [7:0]  pred, v;
      bit          row_last, img_last;
      rb  = eff_row_bytes();
      bpp = clamp_to(bpp_reg, 1, 8);
      h   = eff_height();
      // filter byte at the head of a row
      if (col_pos == 0) begin
        col_pos = 1;
        if (!failed) begin
          if (b > 8'(FILT_PAETH)) begin
            failed = 1'b1;
            pixels_due.push_back('{pixel_byte: 8'h00, row_end: 1'b0, image_end: 1'b0,
                                   status: 1'b1});
          end else begin
            filter = filt_t'(b[2:0]);
          end
        end
        return;
      end
      col      = col_pos - 1;
      row_last = (col + 1 >= rb);
      img_last = row_last && (row_pos + 1 >= h);
      // data byte, rebuilt from left, above and upper-left
      if (!failed) begin
        u = (row_pos > 0) ? int'(above_row[col]) : 0;
        a = (col >= bpp) ? int'(left_hist[(col - bpp) % 8]) : 0;
        c = (row_pos > 0 && col >= bpp) ? int'(ul_hist[(col - bpp) % 8]) : 0;
        case (filter)
          FILT_SUB:   pred = 8'(a);
          FILT_UP:    pred = 8'(u);
          FILT_AVG:   pred = 8'((a + u) / 2);
          FILT_PAETH: begin
            p  = a + u - c;
            da = (p > a) ? p - a : a - p;
            du = (p > u) ? p - u : u - p;
            dc = (p > c) ? p - c : c - p;
            if (da <= du && da <= dc) pred = 8'(a);
            else if (du <= dc) pred = 8'(u);
            else pred = 8'(c);
          end
          default:    pred = 8'h00;
        endcase
        v = b + pred;
        left_hist[col % 8] = v;
        ul_hist[col % 8]   = 8'(u);
        above_row[col]     = v;
        pixels_due.push_back('{pixel_byte: v, row_end: row_last, image_end: img_last,
                               status: 1'b0});
      end
      // advance column, row and image position
      if (row_last) begin
        col_pos = 0;
        if (img_last) begin
          row_pos = 0;
          failed  = 1'b0;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    endfunction

    // compare one pixel transaction with the oldest prediction
    function void check_pixel(pix_t seen);
      pix_t want;
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel transaction: pixel_byte %0h row_end %0b image_end %0b status %0b",
               seen.pixel_byte, seen.row_end, seen.image_end, seen.status);
        mismatches++;
        return;
      end
      want = pixels_due.pop_front();
      if (seen.pixel_byte !== want.pixel_byte) begin
        $error("pixel_byte: expected %0h, got %0h", want.pixel_byte, seen.pixel_byte);
        mismatches++;
      end
      if (seen.row_end !== want.row_end) begin
        $error("row_end: expected %0b, got %0b", want.row_end, seen.row_end);
        mismatches++;
      end
      if (seen.image_end !== want.image_end) begin
        $error("image_end: expected %0b, got %0b", want.image_end, seen.image_end);
        mismatches++;
      end
      if (seen.status !== want.status) begin
        $error("status: expected %0b, got %0b", want.status, seen.status);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  psu_byte_if stream_if ();
  psu_pix_if  pix_if ();

  unfilter_board board;
  int            bytes_sent = 0;
  int            burst_left = 0;
  bit            squeeze_req = 1'b0;

  png_scanline_unfilter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stream_in (stream_if),
    .pixel_out (pix_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // offer one stream byte in bursts with random gaps, return once accepted
  task automatic put_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        stream_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    stream_if.valid       <= 1'b1;
    stream_if.stream_byte <= b;
    do @(posedge clk); while (!stream_if.ready);
    board.take_byte(b);
    bytes_sent++;
  endtask

  // one whole image at the current geometry
  task automatic send_image(input img_flavor_t flavor);
    int unsigned rb, h, bad_row;
    int          sel;
    rb      = board.eff_row_bytes();
    h       = board.eff_height();
    bad_row = $urandom_range(0, h - 1);
    for (int unsigned r = 0; r < h; r++) begin
      if (flavor == IMG_NOISE || (flavor == IMG_BROKEN && r > bad_row))
        put_byte(8'($urandom_range(0, 255)));
      else if (flavor == IMG_BROKEN && r == bad_row)
        put_byte(8'($urandom_range(int'(FILT_PAETH) + 1, 255)));
      else
        put_byte(8'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH))));
      for (int unsigned k = 0; k < rb; k++) begin
        sel = $urandom_range(0, 7);
        put_byte(sel == 0 ? 8'h00 : sel == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // wait for every predicted pixel plus the pipeline depth
  task automatic settle();
    stream_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // new geometry between images, with the block drained
  task automatic next_phase(input logic [15:0] rb, input logic [15:0] bpp,
                            input logic [15:0] h);
    settle();
    write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
    write_reg(CFG_ROW_BYTES, rb);
    write_reg(CFG_BYTES_PER_PX, bpp);
    write_reg(CFG_IMAGE_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  // pixel transactions go to the board
  always @(posedge clk) begin : pixel_monitor
    pix_t seen;
    if (!rst && pix_if.valid && pix_if.ready) begin
      seen.pixel_byte = pix_if.pixel_byte;
      seen.row_end    = pix_if.row_end;
      seen.image_end  = pix_if.image_end;
      seen.status     = pix_if.status;
      board.check_pixel(seen);
    end
  end

  // receiver back-pressure, plus one long hold on request
  initial begin : rx_pattern
    rx_mode_t mode;
    int       span;
    int       tick;
    tick = 0;
    pix_if.ready <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (squeeze_req) begin
          pix_if.ready <= 1'b0;
          repeat (SQUEEZE_CYCLES) @(posedge clk);
          squeeze_req = 1'b0;
        end
        case (mode)
          RX_OPEN:    pix_if.ready <= 1'b1;
          RX_COIN:    pix_if.ready <= 1'($urandom_range(0, 1));
          RX_QUARTER: pix_if.ready <= (tick % 4 == 0);
          default:    pix_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int          target;
    int          pick;
    img_flavor_t flavor;
    board = new();
    rst                   <= 1'b1;
    cfg_write             <= 1'b0;
    cfg_index             <= CFG_ROW_BYTES;
    cfg_data              <= '0;
    stream_if.valid       <= 1'b0;
    stream_if.stream_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: one row of four bytes, no filter
    put_byte(8'(FILT_NONE));
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h80);
    put_byte(8'h7F);

    // every filter once, one byte per pixel, two bytes per row
    next_phase(16'd2, 16'd1, 16'd5);
    put_byte(8'(FILT_NONE));
    put_byte(8'hFF);
    put_byte(8'h01);
    put_byte(8'(FILT_SUB));
    put_byte(8'h01);
    put_byte(8'hFF);
    put_byte(8'(FILT_UP));
    put_byte(8'h80);
    put_byte(8'h80);
    put_byte(8'(FILT_AVG));
    put_byte(8'hFF);
    put_byte(8'h7F);
    put_byte(8'(FILT_PAETH));
    put_byte(8'h10);
    put_byte(8'hF0);

    // unknown filter codes, then a clean image right after the dropped ones
    next_phase(16'd1, 16'd1, 16'd1);
    put_byte(8'hFF);
    put_byte(8'h55);
    put_byte(8'(FILT_PAETH) + 8'd1);
    put_byte(8'hAA);
    put_byte(8'(FILT_AVG));
    put_byte(8'h33);

    // receiver holds off while the stream keeps coming
    next_phase(16'd10, 16'd3, 16'd4);
    squeeze_req = 1'b1;
    send_image(IMG_CLEAN);
    send_image(IMG_CLEAN);

    // random geometries and images
    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 9);
      next_phase(pick == 0 ? 16'd0 :
                 pick == 1 ? 16'($urandom_range(13, 40)) : 16'($urandom_range(1, 12)),
                 16'($urandom_range(0, 65535)),
                 pick == 2 ? 16'd0 :
                 pick == 3 ? 16'($urandom_range(6, 12)) :
                 {3'($urandom_range(0, 7)), 13'($urandom_range(1, 5))});
      repeat ($urandom_range(1, 3)) begin
        pick   = $urandom_range(0, 19);
        flavor = (pick < 17) ? IMG_CLEAN : (pick < 19) ? IMG_BROKEN : IMG_NOISE;
        send_image(flavor);
      end
    end

    // geometry extremes: all registers below range
    next_phase(16'd0, 16'd0, 16'd0);
    repeat (3) send_image(IMG_CLEAN);
    send_image(IMG_BROKEN);

    settle();
    if (board.mismatches == 0) begin
      $display("tb_png_scanline_unfilter_unit: done, clean");
    end else begin
      $display("tb_png_scanline_unfilter_unit: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb_png_scanline_unfilter_unit: done, errors");
    $finish;
  end

endmodule
